// ===== src/ufr_pkg.sv =====
// shared constants for the update frame receiver
// no dependencies
package ufr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int PAY_AW = $clog2(MAX_PAYLOAD);
  localparam int STEP_W = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0] HDR1 = 8'h55;
  localparam logic [7:0] HDR2 = 8'hAA;
  localparam logic [7:0] REPLY_ACK = 8'h06;
  localparam logic [7:0] REPLY_NACK = 8'h07;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_LEN = 3'd2;
  localparam logic [2:0] PH_CMD = 3'd3;
  localparam logic [2:0] PH_PAY = 3'd4;
  localparam logic [2:0] PH_CRCL = 3'd5;
  localparam logic [2:0] PH_CRCH = 3'd6;

  localparam logic [7:0] FRM_START = 8'd0;
  localparam logic [7:0] FRM_COMPLETE = 8'd1;
  localparam logic [7:0] FRM_WRITE = 8'd2;
  localparam logic [7:0] FRM_COPY = 8'd3;

  localparam logic [2:0] OP_REPLY = 3'd0;
  localparam logic [2:0] OP_ERASE = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_COPY = 3'd3;
  localparam logic [2:0] OP_SIZE = 3'd4;
  localparam logic [2:0] OP_FLAG = 3'd5;
  localparam logic [2:0] OP_RESET = 3'd6;

  localparam logic [2:0] JOB_NACK = 3'd0;
  localparam logic [2:0] JOB_START = 3'd1;
  localparam logic [2:0] JOB_COMPLETE = 3'd2;
  localparam logic [2:0] JOB_WRITE = 3'd3;
  localparam logic [2:0] JOB_COPY = 3'd4;

  localparam logic [7:0] REG_DOWNLOAD_BASE = 8'd0;
  localparam logic [7:0] REG_APP_BASE = 8'd1;

endpackage

// ===== src/ufr_if.sv =====
// channel interfaces of the update frame receiver: byte input, result output, config write
// depends on ufr_pkg
interface ufr_rx_if import ufr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ufr_res_if import ufr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] address;
  logic [31:0] source_address;
  logic [31:0] data;
  logic [7:0]  run_length;
  logic        last;

  modport source (output valid, output op, output address, output source_address,
                  output data, output run_length, output last, input ready);
  modport sink (input valid, input op, input address, input source_address,
                input data, input run_length, input last, output ready);
endinterface

interface ufr_cfg_if import ufr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/update_frame_receiver.sv =====
// update frame receiver top level: frame parser, bitwise crc unit, result sequencer
// depends on ufr_pkg and the channel interfaces in ufr_if.sv
//
// usage: rx carries received serial bytes, res carries flash and reply operations,
// cfg writes download_base (index 0) and app_base (index 1); cfg is always ready.
// rx is ready only while the sequencer is idle. header and crc bytes are only
// accepted; an in-range length byte, the command and each payload byte are then
// followed by eight steps of the one-bit crc shifter. a byte that causes results
// holds rx low until its last result is loaded: each result is a payload memory
// read, then a load of the output register. a write frame of n bytes gives n
// write results and one ack.
// the output register lets the next byte be accepted while the final result waits.
// a stalled res holds the sequencer before loading the next result; nothing is lost.
// reset (synchronous, active high) returns to hunting the header, clears pointers,
// total and both base registers; the payload memory is not cleared.
module update_frame_receiver import ufr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  ufr_rx_if.sink   rx,
  ufr_res_if.source res,
  ufr_cfg_if.sink  cfg
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CRC  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  logic [1:0]  state;
  logic [2:0]  phase;
  logic [7:0]  frame_length;
  logic [7:0]  frame_command;
  logic [7:0]  byte_counter;
  logic [15:0] crc;
  logic [2:0]  crc_cnt;
  logic [7:0]  crc_low;
  logic [31:0] download_base;
  logic [31:0] app_base;
  logic [31:0] download_pointer;
  logic [31:0] app_pointer;
  logic [31:0] total_bytes;
  logic [2:0]  job;
  logic [STEP_W-1:0] step;
  logic [7:0]  payload_mem [MAX_PAYLOAD];
  logic [7:0]  rd_data;

  logic        out_valid;
  logic [2:0]  out_op;
  logic [31:0] out_address;
  logic [31:0] out_source;
  logic [31:0] out_data;
  logic [7:0]  out_run;
  logic        out_last;

  logic        rx_take;
  logic        pay_write;
  logic        slot_free;
  logic        load;
  logic [7:0]  b;
  logic [7:0]  byte_counter_next;
  logic [15:0] crc_step;

  logic [2:0]  r_op;
  logic [31:0] r_address;
  logic [31:0] r_source;
  logic [31:0] r_data;
  logic [7:0]  r_run;
  logic        r_last;

  assign b = rx.rx_byte;
  assign rx.ready = (state == S_IDLE);
  assign rx_take = rx.valid && rx.ready;
  assign pay_write = rx_take && (phase == PH_PAY);
  assign byte_counter_next = byte_counter + 8'd1;
  assign slot_free = !out_valid || res.ready;
  assign load = (state == S_EMIT) && slot_free;
  assign crc_step = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
  assign cfg.ready = 1'b1;

  assign res.valid = out_valid;
  assign res.op = out_op;
  assign res.address = out_address;
  assign res.source_address = out_source;
  assign res.data = out_data;
  assign res.run_length = out_run;
  assign res.last = out_last;

  // result for the current job and step
  always_comb begin
    r_op = OP_REPLY;
    r_address = '0;
    r_source = '0;
    r_data = '0;
    r_run = '0;
    r_last = 1'b0;
    case (job)
      JOB_NACK: begin
        r_data = {24'd0, REPLY_NACK};
        r_last = 1'b1;
      end
      JOB_START: begin
        if (step == '0) begin
          r_op = OP_ERASE;
          r_address = download_base + 32'd4;
        end else begin
          r_data = {24'd0, REPLY_ACK};
          r_last = 1'b1;
        end
      end
      JOB_COMPLETE: begin
        case (step[1:0])
          2'd0: r_data = {24'd0, REPLY_ACK};
          2'd1: begin
            r_op = OP_SIZE;
            r_address = download_base;
            r_data = total_bytes;
          end
          2'd2: begin
            r_op = OP_FLAG;
            r_data = 32'd1;
          end
          default: begin
            r_op = OP_RESET;
            r_last = 1'b1;
          end
        endcase
      end
      JOB_WRITE: begin
        if (8'(step) == frame_length) begin
          r_data = {24'd0, REPLY_ACK};
          r_last = 1'b1;
        end else begin
          r_op = OP_WRITE;
          r_address = download_pointer + 32'(step);
          r_data = {24'd0, rd_data};
        end
      end
      default: begin
        if (step == '0) begin
          r_op = OP_COPY;
          r_address = download_pointer;
          r_source = app_pointer;
          r_run = frame_length;
        end else begin
          r_data = {24'd0, REPLY_ACK};
          r_last = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pay_write) begin
      payload_mem[byte_counter[PAY_AW-1:0]] <= b;
    end
    if (state == S_RD) begin
      rd_data <= payload_mem[step[PAY_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_op <= r_op;
      out_address <= r_address;
      out_source <= r_source;
      out_data <= r_data;
      out_run <= r_run;
      out_last <= r_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      download_base <= '0;
      app_base <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DOWNLOAD_BASE: download_base <= cfg.data;
        REG_APP_BASE:      app_base <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_HUNT;
      frame_length <= '0;
      frame_command <= '0;
      byte_counter <= '0;
      crc <= CRC_INIT;
      crc_cnt <= '0;
      crc_low <= '0;
      download_pointer <= '0;
      app_pointer <= '0;
      total_bytes <= '0;
      job <= JOB_NACK;
      step <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (rx_take) begin
            step <= '0;
            crc_cnt <= '0;
            case (phase)
              PH_HUNT: begin
                if (b == HDR1) phase <= PH_HDR2;
              end
              PH_HDR2: begin
                if (b == HDR2) phase <= PH_LEN;
                else if (b != HDR1) phase <= PH_HUNT;
              end
              PH_LEN: begin
                if (b > MAX_LEN) begin
                  job <= JOB_NACK;
                  phase <= PH_HUNT;
                  state <= S_RD;
                end else begin
                  frame_length <= b;
                  crc <= CRC_INIT ^ {8'd0, b};
                  byte_counter <= '0;
                  phase <= PH_CMD;
                  state <= S_CRC;
                end
              end
              PH_CMD: begin
                frame_command <= b;
                crc <= crc ^ {8'd0, b};
                byte_counter <= '0;
                phase <= (frame_length == 8'd0) ? PH_CRCL : PH_PAY;
                state <= S_CRC;
              end
              PH_PAY: begin
                crc <= crc ^ {8'd0, b};
                byte_counter <= byte_counter_next;
                if (byte_counter_next >= frame_length) phase <= PH_CRCL;
                state <= S_CRC;
              end
              PH_CRCL: begin
                crc_low <= b;
                phase <= PH_CRCH;
              end
              PH_CRCH: begin
                phase <= PH_HUNT;
                if ({b, crc_low} != crc) begin
                  job <= JOB_NACK;
                  state <= S_RD;
                end else begin
                  case (frame_command)
                    FRM_START: begin
                      job <= JOB_START;
                      state <= S_RD;
                    end
                    FRM_COMPLETE: begin
                      job <= JOB_COMPLETE;
                      state <= S_RD;
                    end
                    FRM_WRITE: begin
                      job <= JOB_WRITE;
                      state <= S_RD;
                    end
                    FRM_COPY: begin
                      job <= JOB_COPY;
                      state <= S_RD;
                    end
                    default: ;
                  endcase
                end
              end
              default: phase <= PH_HUNT;
            endcase
          end
        end
        S_CRC: begin
          crc <= crc_step;
          crc_cnt <= crc_cnt + 3'd1;
          if (crc_cnt == 3'd7) state <= S_IDLE;
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            if (r_last) begin
              state <= S_IDLE;
              case (job)
                JOB_START: begin
                  download_pointer <= download_base + 32'd4;
                  app_pointer <= app_base;
                  total_bytes <= '0;
                end
                JOB_COMPLETE: begin
                  frame_length <= '0;
                  frame_command <= '0;
                  byte_counter <= '0;
                  crc <= CRC_INIT;
                  crc_low <= '0;
                  download_pointer <= '0;
                  app_pointer <= '0;
                  total_bytes <= '0;
                end
                JOB_WRITE, JOB_COPY: begin
                  download_pointer <= download_pointer + 32'(frame_length);
                  app_pointer <= app_pointer + 32'(frame_length);
                  total_bytes <= total_bytes + 32'(frame_length);
                end
                default: ;
              endcase
            end else begin
              step <= step + STEP_W'(1);
              state <= S_RD;
            end
          end
        end
      endcase
    end
  end

  a_crc_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_CRC && crc_cnt == 3'd7) |=> (state == S_IDLE && rx.ready))
    else $error("crc shifter did not finish after eight steps");

  a_reply_code: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.op == OP_REPLY) |->
      (res.data == {24'd0, REPLY_ACK} || res.data == {24'd0, REPLY_NACK}))
    else $error("reply result carries a bad code");

  a_load_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> !(state == S_EMIT && $past(state) == S_RD) || out_valid)
    else $error("pending result dropped");

  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (phase == PH_HUNT))
    else $error("results started while a frame is still being parsed");

endmodule
